// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the sidewinder carver RTL.
// Every macro samples on the rising edge of clk and is disabled while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property check.
`define SMC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Condition in one cycle implies a consequence in the next cycle.
`define SMC_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== hdl/smc_pkg.sv =====
// Shared types and constants for the sidewinder maze carver.
// Used by smc_rem_unit and sidewinder_maze_carver; depends on nothing.
`timescale 1ns / 1ps

package smc_pkg;

  localparam int SIDE_W    = 10;
  localparam int RUN_W     = 9;
  localparam int PICK_W    = 16;
  localparam int COORD_W   = 32;
  localparam int CFG_IDX_W = 3;
  localparam int MODE_W    = 2;
  localparam int CNT_W     = $clog2(PICK_W);

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SWEEP_MODE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_X      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_Y      = 3'd4;

  // Bits of sweep_mode: set means west, set means south.
  localparam int MODE_WEST_BIT  = 1;
  localparam int MODE_SOUTH_BIT = 0;

  typedef struct packed {
    logic              coin;
    logic [PICK_W-1:0] pick;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] open_x;
    logic signed [COORD_W-1:0] open_y;
    logic                      last;
    logic                      maze_done;
  } out_item_t;

  typedef struct packed {
    logic              start;
    logic [PICK_W-1:0] dividend;
    logic [RUN_W-1:0]  divisor;
  } rem_req_t;

  typedef struct packed {
    logic             done;
    logic [RUN_W-1:0] remainder;
  } rem_rsp_t;

endpackage

// ===== hdl/smc_rem_unit.sv =====
// Bit-serial restoring remainder unit: 16-bit dividend modulo a 9-bit divisor.
// Depends on smc_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module smc_rem_unit import smc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  rem_req_t req,
  output rem_rsp_t rsp
);

  logic             busy;
  logic             done;
  logic [CNT_W-1:0] cnt;
  logic [PICK_W-1:0] quo;
  logic [RUN_W-1:0] rem;
  logic [RUN_W-1:0] divisor;

  logic [RUN_W:0]   trial;
  logic [RUN_W:0]   diff;
  logic             fits;
  logic [RUN_W-1:0] rem_next;

  // One dividend bit per cycle, most significant first.
  assign trial    = {rem, quo[PICK_W-1]};
  assign diff     = trial - {1'b0, divisor};
  assign fits     = (trial >= {1'b0, divisor});
  assign rem_next = fits ? diff[RUN_W-1:0] : trial[RUN_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(PICK_W - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo     <= req.dividend;
      rem     <= '0;
      divisor <= req.divisor;
    end else if (busy) begin
      quo <= {quo[PICK_W-2:0], 1'b0};
      rem <= rem_next;
    end
  end

  assign rsp.done      = done;
  assign rsp.remainder = rem;

  `SMC_ASSERT(a_no_restart_busy, req.start |-> !busy, "start while remainder unit busy")
  `SMC_ASSERT(a_rem_below_div, busy |-> (rem < divisor), "partial remainder not below divisor")

endmodule

// ===== hdl/sidewinder_maze_carver.sv =====
// Top level of the sidewinder maze carver: configuration, cell sequencer, output register.
// Depends on smc_pkg, smc_rem_unit and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// The carver walks the odd cells of an odd-sized grid in the order set by
// sweep_mode and takes one item of random values per cell. For each item it
// emits the absolute coordinates of the cell, then, when a wall is carved,
// the coordinates of that wall; the final result of an item carries last, and
// every result of the item that ends the maze carries maze_done, after which
// the next item starts a new maze. Items are taken one at a time: the next
// item is let in once the sequencer is idle again, after the cell result of
// an item that gives a single result and after the wall result of one that
// carves along the sweep. An item that closes a run off the first row also
// waits for the bit-serial remainder unit, which reduces the 16-bit pick
// modulo the run length one dividend bit per cycle: the cell result is loaded
// as the unit starts, then the unit shifts, raises its done flag, and the
// wall result is loaded. A result still waiting in the output register holds
// back the next result of an item. The output register lets an item be
// accepted while the previous result is still waiting to be taken. Any
// write to a defined register restarts the sweep at its first cell; the
// input is stalled while a configuration write is offered, and the carver
// takes no item in the cycle after such a write (or after reset) while it
// reloads its position. Even sizes have their low bit forced to one and a
// size of one is taken as three.
module sidewinder_maze_carver import smc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COORD_W-1:0]   cfg_data
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CELL = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_WALL = 2'd3;

  // Configuration registers.
  logic [SIDE_W-1:0]  grid_width;
  logic [SIDE_W-1:0]  grid_height;
  logic [MODE_W-1:0]  sweep_mode;
  logic [COORD_W-1:0] base_x;
  logic [COORD_W-1:0] base_y;

  // Sequencer and walk state.
  logic [1:0]        state;
  logic              restart_pend;
  logic [SIDE_W-1:0] cell_col;
  logic [SIDE_W-1:0] cell_row;
  logic [SIDE_W-1:0] run_first_col;
  logic [RUN_W-1:0]  run_count;
  logic              item_coin;
  logic [PICK_W-1:0] item_pick;
  logic [SIDE_W-1:0] wall_col;
  logic [SIDE_W-1:0] wall_row;

  // Derived geometry.
  logic [SIDE_W-1:0] w_or, h_or, eff_w, eff_h;
  logic              east, north;
  logic [SIDE_W-1:0] first_col, last_col, first_row, last_row;

  // Decisions for the current cell.
  logic at_edge, boundary, carve, need_wall, maze_end;
  logic [SIDE_W-1:0] col_step, row_step, col_side, row_back, sel_col, sel_off;

  // Position after the current item.
  logic [SIDE_W-1:0] cell_col_next, cell_row_next, run_first_col_next;
  logic [RUN_W-1:0]  run_count_next;

  logic      in_accept, cfg_write, cfg_hit;
  logic      out_free, load_cell, load_wall;
  rem_req_t  rem_req;
  rem_rsp_t  rem_rsp;

  assign w_or  = grid_width | SIDE_W'(1);
  assign h_or  = grid_height | SIDE_W'(1);
  assign eff_w = (w_or == SIDE_W'(1)) ? SIDE_W'(3) : w_or;
  assign eff_h = (h_or == SIDE_W'(1)) ? SIDE_W'(3) : h_or;
  assign east  = !sweep_mode[MODE_WEST_BIT];
  assign north = !sweep_mode[MODE_SOUTH_BIT];

  assign first_col = east  ? SIDE_W'(1) : eff_w - SIDE_W'(2);
  assign last_col  = east  ? eff_w - SIDE_W'(2) : SIDE_W'(1);
  assign first_row = north ? SIDE_W'(1) : eff_h - SIDE_W'(2);
  assign last_row  = north ? eff_h - SIDE_W'(2) : SIDE_W'(1);

  // The first row of the sweep always extends, except at the row's edge.
  assign at_edge   = (cell_col == last_col);
  assign boundary  = (cell_row == first_row);
  assign carve     = !at_edge && (boundary || !item_coin);
  assign need_wall = carve || !boundary;
  assign maze_end  = at_edge && (cell_row == last_row);

  assign col_step = east  ? cell_col + SIDE_W'(2) : cell_col - SIDE_W'(2);
  assign row_step = north ? cell_row + SIDE_W'(2) : cell_row - SIDE_W'(2);
  assign col_side = east  ? cell_col + SIDE_W'(1) : cell_col - SIDE_W'(1);
  // The row-side wall lies toward the previous row.
  assign row_back = north ? cell_row - SIDE_W'(1) : cell_row + SIDE_W'(1);
  // Chosen run cell: two columns per run position from the run's first cell.
  assign sel_off  = {rem_rsp.remainder, 1'b0};
  assign sel_col  = east ? run_first_col + sel_off : run_first_col - sel_off;

  always_comb begin
    if (at_edge) begin
      cell_col_next      = first_col;
      cell_row_next      = maze_end ? first_row : row_step;
      run_first_col_next = first_col;
      run_count_next     = '0;
    end else begin
      cell_col_next      = col_step;
      cell_row_next      = cell_row;
      run_first_col_next = carve ? run_first_col : col_step;
      run_count_next     = carve ? run_count + 1'b1 : '0;
    end
  end

  // A configuration write takes precedence, so an item never starts on the
  // edge that changes the registers.
  assign in_stall  = (state != S_IDLE) || restart_pend || cfg_valid;
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = (state == S_IDLE);
  assign cfg_write = cfg_valid && cfg_ready;
  assign cfg_hit   = (cfg_index == CFG_GRID_WIDTH) || (cfg_index == CFG_GRID_HEIGHT) ||
                     (cfg_index == CFG_SWEEP_MODE) || (cfg_index == CFG_BASE_X) ||
                     (cfg_index == CFG_BASE_Y);

  assign out_free  = !out_valid || !out_stall;
  assign load_cell = (state == S_CELL) && out_free;
  assign load_wall = (state == S_WALL) && out_free;

  // The run length includes the current cell, so the divisor is never zero.
  assign rem_req.start    = load_cell && !carve && !boundary;
  assign rem_req.dividend = item_pick;
  assign rem_req.divisor  = run_count + 1'b1;

  smc_rem_unit u_rem (
    .clk (clk),
    .rst (rst),
    .req (rem_req),
    .rsp (rem_rsp)
  );

  // Configuration registers and the restart request.
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width   <= SIDE_W'(3);
      grid_height  <= SIDE_W'(3);
      sweep_mode   <= '0;
      base_x       <= '0;
      base_y       <= '0;
      restart_pend <= 1'b1;
    end else begin
      if (state == S_IDLE) begin
        restart_pend <= 1'b0;
      end
      if (cfg_write) begin
        case (cfg_index)
          CFG_GRID_WIDTH:  grid_width  <= cfg_data[SIDE_W-1:0];
          CFG_GRID_HEIGHT: grid_height <= cfg_data[SIDE_W-1:0];
          CFG_SWEEP_MODE:  sweep_mode  <= cfg_data[MODE_W-1:0];
          CFG_BASE_X:      base_x      <= cfg_data;
          CFG_BASE_Y:      base_y      <= cfg_data;
          default:         ;
        endcase
        if (cfg_hit) begin
          restart_pend <= 1'b1;
        end
      end
    end
  end

  // Sequencer and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_accept) begin
            state <= S_CELL;
          end
        end
        S_CELL: begin
          if (load_cell) begin
            out_valid <= 1'b1;
            if (carve) begin
              state <= S_WALL;
            end else if (!boundary) begin
              state <= S_DIV;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_DIV: begin
          if (rem_rsp.done) begin
            state <= S_WALL;
          end
        end
        S_WALL: begin
          if (load_wall) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Walk position, the item's random values, the wall and the output item.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && restart_pend) begin
      cell_col      <= first_col;
      cell_row      <= first_row;
      run_first_col <= first_col;
      run_count     <= '0;
    end else if ((load_cell && !need_wall) || load_wall) begin
      cell_col      <= cell_col_next;
      cell_row      <= cell_row_next;
      run_first_col <= run_first_col_next;
      run_count     <= run_count_next;
    end

    if (in_accept) begin
      item_coin <= in_data.coin;
      item_pick <= in_data.pick;
    end

    if (load_cell) begin
      wall_col <= col_side;
      wall_row <= cell_row;
    end else if (state == S_DIV && rem_rsp.done) begin
      wall_col <= sel_col;
      wall_row <= row_back;
    end

    if (load_cell) begin
      out_data.open_x    <= base_x + COORD_W'(cell_col);
      out_data.open_y    <= base_y + COORD_W'(cell_row);
      out_data.last      <= !need_wall;
      out_data.maze_done <= maze_end;
    end else if (load_wall) begin
      out_data.open_x    <= base_x + COORD_W'(wall_col);
      out_data.open_y    <= base_y + COORD_W'(wall_row);
      out_data.last      <= 1'b1;
      out_data.maze_done <= maze_end;
    end
  end

  `SMC_ASSERT(a_rem_done_in_div, rem_rsp.done |-> (state == S_DIV), "remainder outside divide")
  `SMC_ASSERT_NEXT(a_cell_then_wall, load_cell && need_wall, (state == S_DIV) || (state == S_WALL), "wall result skipped")
  `SMC_ASSERT(a_cell_odd, !restart_pend |-> (cell_col[0] && cell_row[0]), "cell position not odd")

endmodule
